>>> rtl/pwg_pkg.sv
// Shared types and constants for the PWG raster line decoder.
`timescale 1ns / 1ps

package pwg_pkg;

   localparam int unsigned POS_W   = 15;
   localparam int unsigned LINES_W = 9;
   localparam int unsigned RUN_W   = 11;
   localparam int unsigned WB_W    = 19;
   localparam int unsigned BPP_W   = 7;
   localparam int unsigned CSR_W   = 15;

   localparam logic [7:0] LITERAL_BASE = 8'h80;
   localparam logic [8:0] LITERAL_SPAN = 9'd257;
   localparam logic [3:0] PIXEL_ROUND  = 4'd7;

   localparam logic CSR_BITS_PER_PIXEL = 1'b0;
   localparam logic CSR_LINE_WIDTH     = 1'b1;

   localparam logic [BPP_W-1:0] BPP_RESET   = 7'd8;
   localparam logic [POS_W-1:0] WIDTH_RESET = 15'd2048;

   typedef enum logic [1:0] {
      PH_REPEAT  = 2'd0,
      PH_CONTROL = 2'd1,
      PH_PIXEL   = 2'd2,
      PH_LITERAL = 2'd3
   } phase_type;

   typedef struct packed {
      logic       func;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       end_of_line;
      logic       byte_taken;
      logic       error;
   } rsp_type;

   typedef struct packed {
      logic       is_pull;
      logic [7:0] data_byte;
   } entry_type;

endpackage

>>> rtl/pwg_front.sv
// Input side: accepts transactions, classifies them and queues them for the decoder.
`timescale 1ns / 1ps

module pwg_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pwg_pkg::req_type   req_payload,
   output logic               entry_valid,
   output pwg_pkg::entry_type entry,
   input  logic               entry_pop
);

   pwg_pkg::entry_type queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign req_stall   = (count_ff == 2'd2);
   assign push        = req_valid && !req_stall;
   assign entry_valid = (count_ff != 2'd0);
   assign pop         = entry_pop && entry_valid;
   assign entry       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff].is_pull   <= req_payload.func;
         queue_ff[wr_ptr_ff].data_byte <= req_payload.data_byte;
      end
   end

endmodule

>>> rtl/pwg_back.sv
// Decoder core: run-length expansion into the line store, line readout and result register.
`timescale 1ns / 1ps

module pwg_back #(
   parameter int unsigned LINE_BYTES = 16384
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [pwg_pkg::BPP_W-1:0]        bits_per_pixel,
   input  logic [pwg_pkg::POS_W-1:0]        line_width,
   input  logic                             entry_valid,
   input  pwg_pkg::entry_type               entry,
   output logic                             entry_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output pwg_pkg::rsp_type                 rsp_payload
);

   localparam int unsigned AW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_EXEC    = 7'b0000010,
      ST_READ    = 7'b0000100,
      ST_MOD     = 7'b0001000,
      ST_FILL_RD = 7'b0010000,
      ST_FILL_WR = 7'b0100000,
      ST_RESP    = 7'b1000000
   } state_type;

   logic [7:0] store_mem [LINE_BYTES];
   logic [7:0] store_q;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]    mem_wdata;

   state_type                     state_ff, state_in;
   pwg_pkg::phase_type            phase_ff, phase_in;
   logic [pwg_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [pwg_pkg::LINES_W-1:0]   lines_ff, lines_in;
   logic [pwg_pkg::RUN_W-1:0]     run_ff, run_in;
   logic                          err_ff, err_in;
   logic                          pull_ff, pull_in;
   logic [7:0]                    byte_ff, byte_in;
   logic                          inr_ff, inr_in;
   logic                          fok_ff, fok_in;
   logic [3:0]                    rem_ff, rem_in;
   logic [pwg_pkg::POS_W-1:0]     sh_ff, sh_in;
   logic [3:0]                    cnt_ff, cnt_in;
   pwg_pkg::rsp_type              res_ff, res_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   pwg_pkg::rsp_type              rsp_ff, rsp_in;

   logic [4:0]                    pb_raw;
   logic [3:0]                    pb;
   logic [pwg_pkg::WB_W-1:0]      wb;
   logic                          emitting;
   logic [8:0]                    run_len;
   logic [pwg_pkg::RUN_W-1:0]     count;
   logic [pwg_pkg::POS_W-1:0]     pos_inc;
   logic [pwg_pkg::RUN_W-1:0]     run_dec;
   logic [4:0]                    mod_t;
   logic [4:0]                    mod_r;
   logic                          load_rsp;

   function automatic logic [AW-1:0] to_addr(input logic [pwg_pkg::POS_W-1:0] p);
      logic [AW+pwg_pkg::POS_W-1:0] ext;
      ext = {{AW{1'b0}}, p};
      return ext[AW-1:0];
   endfunction

   function automatic logic in_range(input logic [pwg_pkg::POS_W-1:0] p);
      return 32'(p) < 32'(LINE_BYTES);
   endfunction

   always_comb begin
      pb_raw = 5'((8'(bits_per_pixel) + 8'(pwg_pkg::PIXEL_ROUND)) >> 3);
      if (pb_raw == 5'd0) begin
         pb = 4'd1;
      end else if (pb_raw > 5'd8) begin
         pb = 4'd8;
      end else begin
         pb = pb_raw[3:0];
      end
      wb = pwg_pkg::WB_W'(line_width) * pwg_pkg::WB_W'(pb);
      if (byte_ff < pwg_pkg::LITERAL_BASE) begin
         run_len = 9'(byte_ff) + 9'd1;
      end else begin
         run_len = pwg_pkg::LITERAL_SPAN - 9'(byte_ff);
      end
      count    = pwg_pkg::RUN_W'(run_len) * pwg_pkg::RUN_W'(pb);
      emitting = (lines_ff != '0) && (phase_ff == pwg_pkg::PH_REPEAT);
      pos_inc  = pos_ff + 1'b1;
      run_dec  = (run_ff != '0) ? run_ff - 1'b1 : run_ff;
      mod_t    = {rem_ff, sh_ff[pwg_pkg::POS_W-1]};
      mod_r    = (mod_t >= 5'(pb)) ? mod_t - 5'(pb) : mod_t;
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      lines_in  = lines_ff;
      run_in    = run_ff;
      err_in    = err_ff;
      pull_in   = pull_ff;
      byte_in   = byte_ff;
      inr_in    = inr_ff;
      fok_in    = fok_ff;
      rem_in    = rem_ff;
      sh_in     = sh_ff;
      cnt_in    = cnt_ff;
      res_in    = res_ff;
      entry_pop = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = to_addr(pos_ff);
      mem_raddr = to_addr(pos_ff);
      mem_wdata = byte_ff;
      load_rsp  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (entry_valid) begin
               entry_pop = 1'b1;
               pull_in   = entry.is_pull;
               byte_in   = entry.data_byte;
               res_in    = '0;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_RESP;
            if (pull_ff) begin
               if (!err_ff && emitting) begin
                  mem_re   = 1'b1;
                  inr_in   = in_range(pos_ff);
                  state_in = ST_READ;
               end
            end else if (err_ff) begin
               res_in.byte_taken = 1'b1;
            end else if (!emitting) begin
               res_in.byte_taken = 1'b1;
               unique case (phase_ff)
                  pwg_pkg::PH_REPEAT: begin
                     if (wb == '0 || 32'(wb) > 32'(LINE_BYTES)) begin
                        err_in = 1'b1;
                     end else begin
                        lines_in = pwg_pkg::LINES_W'(byte_ff) + 1'b1;
                        pos_in   = '0;
                        phase_in = pwg_pkg::PH_CONTROL;
                     end
                  end
                  pwg_pkg::PH_CONTROL: begin
                     if (pwg_pkg::WB_W'(pos_ff) + pwg_pkg::WB_W'(count) > wb) begin
                        err_in = 1'b1;
                     end else begin
                        run_in   = count;
                        phase_in = (byte_ff < pwg_pkg::LITERAL_BASE) ?
                                   pwg_pkg::PH_PIXEL : pwg_pkg::PH_LITERAL;
                     end
                  end
                  pwg_pkg::PH_PIXEL: begin
                     mem_we   = in_range(pos_ff);
                     pos_in   = pos_inc;
                     run_in   = run_dec;
                     sh_in    = pos_inc;
                     rem_in   = '0;
                     cnt_in   = '0;
                     state_in = ST_MOD;
                  end
                  default: begin
                     mem_we = in_range(pos_ff);
                     pos_in = pos_inc;
                     run_in = run_dec;
                     if (run_dec == '0) begin
                        if (pwg_pkg::WB_W'(pos_inc) >= wb) begin
                           pos_in   = '0;
                           phase_in = pwg_pkg::PH_REPEAT;
                        end else begin
                           phase_in = pwg_pkg::PH_CONTROL;
                        end
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            res_in.out_byte  = inr_ff ? store_q : 8'd0;
            res_in.out_valid = 1'b1;
            if (pwg_pkg::WB_W'(pos_inc) >= wb || pos_inc == '0) begin
               res_in.end_of_line = 1'b1;
               pos_in             = '0;
               lines_in           = lines_ff - 1'b1;
            end else begin
               pos_in = pos_inc;
            end
            state_in = ST_RESP;
         end
         ST_MOD: begin
            rem_in = mod_r[3:0];
            sh_in  = sh_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'(pwg_pkg::POS_W - 1)) begin
               if (mod_r == 5'd0) begin
                  state_in = ST_FILL_RD;
               end else begin
                  state_in = ST_RESP;
                  if (run_ff == '0) begin
                     if (pwg_pkg::WB_W'(pos_ff) >= wb) begin
                        pos_in   = '0;
                        phase_in = pwg_pkg::PH_REPEAT;
                     end else begin
                        phase_in = pwg_pkg::PH_CONTROL;
                     end
                  end
               end
            end
         end
         ST_FILL_RD: begin
            if (run_ff == '0) begin
               if (pwg_pkg::WB_W'(pos_ff) >= wb) begin
                  pos_in   = '0;
                  phase_in = pwg_pkg::PH_REPEAT;
               end else begin
                  phase_in = pwg_pkg::PH_CONTROL;
               end
               state_in = ST_RESP;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = to_addr(pos_ff - pwg_pkg::POS_W'(pb));
               fok_in    = (pos_ff >= pwg_pkg::POS_W'(pb));
               state_in  = ST_FILL_WR;
            end
         end
         ST_FILL_WR: begin
            mem_we    = fok_ff && in_range(pos_ff);
            mem_wdata = store_q;
            pos_in    = pos_inc;
            run_in    = run_ff - 1'b1;
            state_in  = ST_FILL_RD;
         end
         ST_RESP: begin
            res_in.error = err_ff;
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_rsp) begin
         rsp_in       = res_ff;
         rsp_in.error = err_ff;
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= pwg_pkg::PH_REPEAT;
         pos_ff       <= '0;
         lines_ff     <= '0;
         run_ff       <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         lines_ff     <= lines_in;
         run_ff       <= run_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pull_ff <= pull_in;
      byte_ff <= byte_in;
      inr_ff  <= inr_in;
      fok_ff  <= fok_in;
      rem_ff  <= rem_in;
      sh_ff   <= sh_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         store_q <= store_mem[mem_raddr];
      end
   end

endmodule

>>> rtl/pwg_raster_line_decoder_core.sv
// Top level of the PWG raster line decoder: configuration registers, input queue and decoder.
//
// Request transactions carry func and data_byte. With func 0 the data_byte is one byte of the
// compressed stream; with func 1 the transaction pulls one decoded byte of the current line.
// Every request produces exactly one response transaction, in order, with out_byte, out_valid,
// end_of_line, byte_taken and the sticky error flag.
// A two-entry queue takes requests while the decoder works, so req_stall rises only when it
// is full. The decoder handles one transaction at a time: a pull with a line to give reads the
// line store before it responds, a repeat, control or literal byte goes straight to the response,
// and a pixel byte of a repeat run takes a 15-step remainder of the line position by the pixel
// size, then on a completed pixel copies the rest of the run with a store read and write per byte.
// The response sits in an output register; while rsp_stall is high it holds, the decoder
// finishes its current transaction and waits, and the queue keeps filling.
// Reset clears decoder state, error flag and both channels; line store stays undefined until
// written. Configuration must be written through csr_write while idle; this is not enforced.
`timescale 1ns / 1ps

module pwg_raster_line_decoder_core #(
   parameter int unsigned LINE_BYTES = 16384
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  pwg_pkg::req_type            req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output pwg_pkg::rsp_type            rsp_payload,
   input  logic                        csr_write,
   input  logic                        csr_index,
   input  logic [pwg_pkg::CSR_W-1:0]   csr_data
);

   logic [pwg_pkg::BPP_W-1:0] bpp_ff, bpp_in;
   logic [pwg_pkg::POS_W-1:0] width_ff, width_in;
   logic                      entry_valid;
   pwg_pkg::entry_type        entry;
   logic                      entry_pop;

   always_comb begin
      bpp_in   = bpp_ff;
      width_in = width_ff;
      if (csr_write) begin
         unique case (csr_index)
            pwg_pkg::CSR_BITS_PER_PIXEL: bpp_in   = csr_data[pwg_pkg::BPP_W-1:0];
            pwg_pkg::CSR_LINE_WIDTH:     width_in = csr_data[pwg_pkg::POS_W-1:0];
            default:                     bpp_in   = bpp_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff   <= pwg_pkg::BPP_RESET;
         width_ff <= pwg_pkg::WIDTH_RESET;
      end else begin
         bpp_ff   <= bpp_in;
         width_ff <= width_in;
      end
   end

   pwg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .entry_valid (entry_valid),
      .entry       (entry),
      .entry_pop   (entry_pop)
   );

   pwg_back #(
      .LINE_BYTES (LINE_BYTES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .bits_per_pixel (bpp_ff),
      .line_width     (width_ff),
      .entry_valid    (entry_valid),
      .entry          (entry),
      .entry_pop      (entry_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload)
   );

endmodule
